FILE: design/array_table_search_edit_top_assert.svh
// Assertion macros for the table search and edit top level.
`ifndef ARRAY_TABLE_SEARCH_EDIT_TOP_ASSERT_SVH
`define ARRAY_TABLE_SEARCH_EDIT_TOP_ASSERT_SVH

// Check a condition at every rising clock edge outside reset.
`define ATSE_ASSERT_COMB(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ATSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ATSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/atse_pkg.sv
// Package with field widths, command and status codes, and the controller states.
`default_nettype none

package atse_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 9;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_APPEND  = 3'd0;
    localparam cmd_t CMD_INSERT  = 3'd1;
    localparam cmd_t CMD_DELETE  = 3'd2;
    localparam cmd_t CMD_LSEARCH = 3'd3;
    localparam cmd_t CMD_BEXACT  = 3'd4;
    localparam cmd_t CMD_LBOUND  = 3'd5;

    localparam status_t STAT_OK   = 2'd0;
    localparam status_t STAT_FULL = 2'd1;
    localparam status_t STAT_BAD  = 2'd2;
    localparam status_t STAT_MISS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_INS_WR,
        S_LSCAN,
        S_PROBE,
        S_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: design/atse_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module atse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/array_table_search_edit_top.sv
// Top level of the signed-entry table with edit and search commands.
//
// Usage:
//   Input channel s_*: one item per command (s_cmd, s_position, s_operand_value).
//   Result channel m_*: exactly one item per command (m_status, m_found_index,
//   m_entry_count), in command order.
//   The block works on one item at a time. s_ready is high while the controller
//   is idle; a finished result sits in the output register, so the next item is
//   accepted even while the receiver holds m_ready low.
// Command flow (n = entry count, p = position):
//   append, errors, unused codes and tail delete: done in the decode state
//   insert: shift entries p..n-1 up, then write at p (only the write at the tail)
//   delete: shift the entries above p down; linear search: stop at the first hit, n on a miss
//   binary and lower bound: probes <= log2(DEPTH) + 1, an exact hit ends a binary search early
// The single RAM read port sets the pace: shifts and scans move one entry per
// cycle, reads and writes pipelined, and each binary probe waits on the
// registered read.
// Reset (aresetn low at a clock edge) empties the table and drops any result
// still held; stored entries are not cleared, and none is read before it is
// written again. A stalled receiver only delays the return to idle.
`default_nettype none
`include "array_table_search_edit_top_assert.svh"

module array_table_search_edit_top #(
    parameter int DEPTH = 256
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [atse_pkg::CMD_W-1:0]     s_cmd,
    input  wire logic [atse_pkg::POS_W-1:0]     s_position,
    input  wire logic signed [atse_pkg::VAL_W-1:0] s_operand_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [atse_pkg::STATUS_W-1:0]       m_status,
    output logic [atse_pkg::IDX_W-1:0]          m_found_index,
    output logic [atse_pkg::IDX_W-1:0]          m_entry_count
);

    import atse_pkg::*;

    // Address width, count width (holds DEPTH itself), and a compare width
    // that covers both the count and the position field.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    state_t state_reg, state_next;

    cmd_t                    cmd_reg, cmd_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [CW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic [AW-1:0]           wr_addr_reg, wr_addr_next;
    logic [CW-1:0]           cmp_idx_reg, cmp_idx_next;
    status_t                 status_reg, status_next;
    logic [CW-1:0]           found_reg, found_next;

    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [IDX_W-1:0]        m_found_reg, m_found_next;
    logic [IDX_W-1:0]        m_count_reg, m_count_next;

    // RAM port signals
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    // Decode helpers
    logic [XW-1:0] pos_x, cnt_x;
    logic [CW-1:0] pos_c, mid_c, last_idx;
    logic          full, ins_bad, ins_tail, del_bad, del_tail;
    logic          shift_up, lscan_hit, entry_lt, entry_gt, exact_hit, out_free;

    atse_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_x    = XW'(pos_reg);
    assign cnt_x    = XW'(count_reg);
    assign pos_c    = CW'(pos_x);
    assign last_idx = count_reg - CW'(1);
    assign full     = (count_reg == CW'(DEPTH));
    assign ins_bad  = (pos_x > cnt_x);
    assign ins_tail = (pos_x == cnt_x);
    assign del_bad  = (pos_x >= cnt_x);
    assign del_tail = ((pos_x + XW'(1)) == cnt_x);
    assign shift_up = (cmd_reg == CMD_INSERT);

    // Exact search probes the lower midpoint of [lo, hi-1]; lower bound that of [lo, hi].
    assign mid_c = (cmd_reg == CMD_BEXACT) ? lo_reg + ((hi_reg - CW'(1) - lo_reg) >> 1)
                                           : lo_reg + ((hi_reg - lo_reg) >> 1);

    assign lscan_hit = pend_reg && (ram_rdata == val_reg);
    assign entry_lt  = ($signed(ram_rdata) < val_reg);
    assign entry_gt  = ($signed(ram_rdata) > val_reg);
    assign exact_hit = (cmd_reg == CMD_BEXACT) && !entry_lt && !entry_gt;
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_index = m_found_reg;
    assign m_entry_count = m_count_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (cmd_reg)
                    CMD_INSERT: begin
                        if (full || ins_bad) begin
                            state_next = S_DONE;
                        end else if (ins_tail) begin
                            state_next = S_INS_WR;
                        end else begin
                            state_next = S_SHIFT;
                        end
                    end
                    CMD_DELETE: begin
                        if (del_bad || del_tail) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SHIFT;
                        end
                    end
                    CMD_LSEARCH: begin
                        state_next = (count_reg == '0) ? S_DONE : S_LSCAN;
                    end
                    CMD_BEXACT, CMD_LBOUND: begin
                        state_next = S_PROBE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                if (!issue_reg) begin
                    state_next = shift_up ? S_INS_WR : S_DONE;
                end
            end
            S_INS_WR: begin
                state_next = S_DONE;
            end
            S_LSCAN: begin
                if (lscan_hit || (pend_reg && !issue_reg)) begin
                    state_next = S_DONE;
                end
            end
            S_PROBE: begin
                state_next = (lo_reg < hi_reg) ? S_CMP : S_DONE;
            end
            S_CMP: begin
                state_next = exact_hit ? S_DONE : S_PROBE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result register
    always_comb begin
        cmd_next     = cmd_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        rd_idx_next  = rd_idx_reg;
        issue_next   = issue_reg;
        pend_next    = pend_reg;
        wr_addr_next = wr_addr_reg;
        cmp_idx_next = cmp_idx_reg;
        status_next  = status_reg;
        found_next   = found_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_count_next  = m_count_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_cmd;
                    pos_next = s_position;
                    val_next = s_operand_value;
                end
            end
            S_EXEC: begin
                status_next = STAT_OK;
                found_next  = '0;
                pend_next   = 1'b0;
                issue_next  = 1'b1;
                lo_next     = '0;
                hi_next     = count_reg;
                case (cmd_reg)
                    CMD_APPEND: begin
                        if (full) begin
                            status_next = STAT_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = AW'(count_reg);
                            ram_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (full) begin
                            status_next = STAT_FULL;
                        end else if (ins_bad) begin
                            status_next = STAT_BAD;
                        end else begin
                            rd_idx_next = last_idx;
                        end
                    end
                    CMD_DELETE: begin
                        if (del_bad) begin
                            status_next = STAT_BAD;
                        end else if (del_tail) begin
                            count_next = last_idx;
                        end else begin
                            rd_idx_next = pos_c + CW'(1);
                        end
                    end
                    CMD_LSEARCH: begin
                        rd_idx_next = '0;
                        found_next  = count_reg;
                    end
                    CMD_BEXACT: begin
                        status_next = STAT_MISS;
                        found_next  = count_reg;
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                // Write back the entry read last cycle while reading the next one.
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (issue_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(rd_idx_reg);
                    pend_next = 1'b1;
                    if (shift_up) begin
                        wr_addr_next = AW'(rd_idx_reg + CW'(1));
                        if (rd_idx_reg == pos_c) begin
                            issue_next = 1'b0;
                        end else begin
                            rd_idx_next = rd_idx_reg - CW'(1);
                        end
                    end else begin
                        wr_addr_next = AW'(rd_idx_reg - CW'(1));
                        if (rd_idx_reg == last_idx) begin
                            issue_next = 1'b0;
                        end else begin
                            rd_idx_next = rd_idx_reg + CW'(1);
                        end
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!shift_up) begin
                        count_next = last_idx;
                    end
                end
            end
            S_INS_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(pos_c);
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
            end
            S_LSCAN: begin
                if (lscan_hit) begin
                    found_next = cmp_idx_reg;
                end else if (issue_reg) begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(rd_idx_reg);
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    if (rd_idx_reg == last_idx) begin
                        issue_next = 1'b0;
                    end else begin
                        rd_idx_next = rd_idx_reg + CW'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                end
            end
            S_PROBE: begin
                if (lo_reg < hi_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(mid_c);
                    mid_next  = mid_c;
                end else if (cmd_reg == CMD_LBOUND) begin
                    found_next = lo_reg;
                end
            end
            S_CMP: begin
                if (entry_lt) begin
                    lo_next = mid_reg + CW'(1);
                end else if (entry_gt || (cmd_reg == CMD_LBOUND)) begin
                    hi_next = mid_reg;
                end else begin
                    status_next = STAT_OK;
                    found_next  = mid_reg;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = IDX_W'(found_reg);
                    m_count_next  = IDX_W'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        rd_idx_reg   <= rd_idx_next;
        wr_addr_reg  <= wr_addr_next;
        cmp_idx_reg  <= cmp_idx_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_count_reg  <= m_count_next;
    end

    `ATSE_ASSERT_IMP(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr, "read and write hit one entry")
    `ATSE_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "second item taken while busy")
    `ATSE_ASSERT_IMP(a_probe_window, state_reg == S_CMP, lo_reg < hi_reg, "probe outside the search window")
    `ATSE_ASSERT_COMB(a_count_range, count_reg <= CW'(DEPTH), "entry count beyond depth")
    `ATSE_ASSERT_NXT(a_result_load, (state_reg == S_DONE) && out_free, m_valid && s_ready, "result not presented")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the signed-entry table with edit and search commands.
`timescale 1ns / 1ps

module tb_top;
    import atse_pkg::*;

    localparam int DEPTH        = 256;
    localparam int RAND_ITEMS   = 1250;
    localparam int TRIM_LEVEL   = 64;        // keep most searches and shifts short
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int HOLD_CYCLES  = 1200;
    localparam int HOLD_AFTER   = 300;       // results seen before the long hold-off
    localparam int LIMIT_CYCLES = 2_000_000;

    // Command codes the block treats as no-ops.
    localparam cmd_t CMD_SPARE_6 = 3'd6;
    localparam cmd_t CMD_SPARE_7 = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        cmd_t                    cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
    } table_cmd_t;

    typedef struct {
        status_t          status;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] count;
    } table_reply_t;

    typedef struct {
        table_cmd_t   c;
        table_reply_t r;
    } table_job_t;

    // Clock and reset; every block input starts at a known value.
    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [CMD_W-1:0]        s_cmd           = '0;
    logic [POS_W-1:0]        s_position      = '0;
    logic signed [VAL_W-1:0] s_operand_value = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [STATUS_W-1:0]     m_status;
    logic [IDX_W-1:0]        m_found_index;
    logic [IDX_W-1:0]        m_entry_count;

    always #2 aclk = ~aclk;

    array_table_search_edit_top #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_position     (s_position),
        .s_operand_value(s_operand_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_index  (m_found_index),
        .m_entry_count  (m_entry_count)
    );

    // Shadow table: the predictor's own copy of the entries and the fill count.
    logic signed [VAL_W-1:0] shadow_entry [DEPTH];
    int                      shadow_count = 0;

    table_job_t   job_backlog [$];   // commands waiting to be offered, with their replies
    table_reply_t replies_due [$];   // replies of accepted commands, oldest first

    int jobs_total     = 0;
    int accepted_total = 0;
    int replies_seen   = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int peak_count     = 0;
    int cmd_tally    [8];
    int status_tally [4];

    // Predict one command: update the shadow table and return the reply it gives.
    function automatic table_reply_t apply_table_cmd(table_cmd_t c);
        table_reply_t r;
        int           lo;
        int           hi;
        int           mid;
        int           i;
        bit           hit;
        r.status = STAT_OK;
        r.index  = '0;
        lo       = 0;
        hi       = shadow_count;
        hit      = 1'b0;
        case (c.cmd)
            CMD_APPEND: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_entry[shadow_count] = c.val;
                    shadow_count++;
                end
            end
            CMD_INSERT: begin
                // Full is checked before the position.
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (int'(c.pos) > shadow_count) begin
                    r.status = STAT_BAD;
                end else begin
                    for (i = shadow_count; i > int'(c.pos); i--)
                        shadow_entry[i] = shadow_entry[i - 1];
                    shadow_entry[c.pos] = c.val;
                    shadow_count++;
                end
            end
            CMD_DELETE: begin
                // An empty table fails here too, since no position is below zero.
                if (int'(c.pos) >= shadow_count) begin
                    r.status = STAT_BAD;
                end else begin
                    for (i = int'(c.pos); i + 1 < shadow_count; i++)
                        shadow_entry[i] = shadow_entry[i + 1];
                    shadow_count--;
                end
            end
            CMD_LSEARCH: begin
                r.index = IDX_W'(shadow_count);
                for (i = 0; i < shadow_count && !hit; i++) begin
                    if (shadow_entry[i] == c.val) begin
                        r.index = IDX_W'(i);
                        hit     = 1'b1;
                    end
                end
            end
            CMD_BEXACT: begin
                // Probe the lower middle of [lo, hi); the first probe that matches wins.
                r.status = STAT_MISS;
                r.index  = IDX_W'(shadow_count);
                while (lo < hi && !hit) begin
                    mid = lo + (hi - 1 - lo) / 2;
                    if (shadow_entry[mid] < c.val) begin
                        lo = mid + 1;
                    end else if (shadow_entry[mid] > c.val) begin
                        hi = mid;
                    end else begin
                        r.status = STAT_OK;
                        r.index  = IDX_W'(mid);
                        hit      = 1'b1;
                    end
                end
            end
            CMD_LBOUND: begin
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_entry[mid] < c.val)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                r.index = IDX_W'(lo);
            end
            default: begin
            end
        endcase
        r.count = IDX_W'(shadow_count);
        return r;
    endfunction

    // Predict a command now and park it, with its reply, for the driver.
    function automatic void queue_cmd(cmd_t cmd, logic [POS_W-1:0] pos,
                                      logic signed [VAL_W-1:0] val);
        table_job_t j;
        j.c.cmd = cmd;
        j.c.pos = pos;
        j.c.val = val;
        j.r     = apply_table_cmd(j.c);
        job_backlog.push_back(j);
        jobs_total++;
        cmd_tally[cmd]++;
        status_tally[j.r.status]++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endfunction

    // Draw a value or key: often one already stored, so searches hit and duplicates form.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30 && shadow_count > 0)
            return shadow_entry[$urandom_range(0, shadow_count - 1)];
        if (r < 40) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (r < 65)
            return VAL_W'(int'($urandom_range(0, 200)) - 100);
        return $urandom;
    endfunction

    // Stretches of no idling on both sides every fourth window of 150 items.
    function automatic int pick_send_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((accepted_total / 150) % 4 == 1)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_sink_stall();
        int r;
        r = $urandom_range(0, 99);
        if ((replies_seen / 150) % 4 == 1)
            return 0;
        if (r < 75)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Driver: offer the next parked command; hold it until accepted, then
    // pass its reply on to the checker and idle for the chosen gap.
    int         gap_left = 0;
    table_job_t cur_job;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                replies_due.push_back(cur_job.r);
                accepted_total <= accepted_total + 1;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (job_backlog.size() != 0) begin
                cur_job          = job_backlog.pop_front();
                s_cmd           <= cur_job.c.cmd;
                s_position      <= cur_job.c.pos;
                s_operand_value <= cur_job.c.val;
                s_valid         <= 1'b1;
                gap_left        <= pick_send_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long hold-off on the result side, counted here, so the block fills and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && replies_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each accepted result against the oldest reply due, then
    // pick the next ready level.
    int stall_left = 0;

    always @(posedge aclk) begin : result_check
        table_reply_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                replies_seen <= replies_seen + 1;
                if (replies_due.size() == 0) begin
                    $error("result with no command pending: status %0d index %0d count %0d",
                           m_status, m_found_index, m_entry_count);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, actual %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_found_index !== want.index) begin
                        $error("m_found_index: expected %0d, actual %0d",
                               want.index, m_found_index);
                        fail_count++;
                    end
                    if (m_entry_count !== want.count) begin
                        $error("m_entry_count: expected %0d, actual %0d",
                               want.count, m_entry_count);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready    <= 1'b1;
                stall_left <= pick_sink_stall();
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles with %0d of %0d results in",
                     cycle_count, replies_seen, jobs_total);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Build the whole command list up front, release reset, wait out the results.
    initial begin : stimulus
        int                      first_random;
        int                      epoch;
        int                      target;
        int                      n_ops;
        int                      k;
        int                      i;
        int                      r;
        int                      slot;
        int                      sel;
        bit                      noisy;
        bit                      ordered;
        logic signed [VAL_W-1:0] v;
        logic [POS_W-1:0]        p;

        foreach (cmd_tally[n])
            cmd_tally[n] = 0;
        foreach (status_tally[n])
            status_tally[n] = 0;

        // Directed: searches, delete and insert on the empty table first, then a small table.
        queue_cmd(CMD_LSEARCH, 8'd0, 32'sd5);       // linear miss gives count 0
        queue_cmd(CMD_BEXACT, 8'd0, 32'sd5);        // binary search on empty: not found
        queue_cmd(CMD_LBOUND, 8'd0, VAL_MAX);       // lower bound on empty: 0
        queue_cmd(CMD_DELETE, 8'd0, 32'sd0);        // delete when empty
        queue_cmd(CMD_INSERT, 8'd1, 32'sd7);        // position past the count
        queue_cmd(CMD_INSERT, 8'd0, 32'sd0);        // insert at position 0 of an empty table
        queue_cmd(CMD_INSERT, 8'd0, VAL_MIN);       // insert at head with a shift
        queue_cmd(CMD_APPEND, 8'hFF, VAL_MAX);
        queue_cmd(CMD_INSERT, 8'd2, 32'sd5);        // insert in the middle
        queue_cmd(CMD_INSERT, 8'd4, VAL_MAX);       // insert at the count acts as append
        queue_cmd(CMD_INSERT, 8'd6, 32'sd1);        // bad position
        queue_cmd(CMD_INSERT, 8'hFF, 32'sd1);       // bad position, all ones
        // Table now holds MIN, 0, 5, MAX, MAX.
        queue_cmd(CMD_LSEARCH, 8'd0, VAL_MAX);
        queue_cmd(CMD_LSEARCH, 8'hFF, 32'sd7);      // linear miss gives the count
        queue_cmd(CMD_BEXACT, 8'd0, VAL_MIN);
        queue_cmd(CMD_BEXACT, 8'd0, VAL_MAX);       // duplicate: first probed match
        queue_cmd(CMD_BEXACT, 8'd0, 32'sd1);        // binary miss
        queue_cmd(CMD_LBOUND, 8'd0, VAL_MIN);
        queue_cmd(CMD_LBOUND, 8'd0, 32'sd1);
        queue_cmd(CMD_LBOUND, 8'd0, VAL_MAX);
        queue_cmd(CMD_DELETE, 8'd4, 32'sd0);        // delete at the tail
        queue_cmd(CMD_DELETE, 8'd0, 32'sd0);        // delete at the head with a shift
        queue_cmd(CMD_DELETE, 8'd3, 32'sd0);        // position equal to the count
        queue_cmd(CMD_DELETE, 8'hFF, 32'sd0);
        queue_cmd(CMD_DELETE, 8'd2, 32'sd0);        // leaves 0, 5
        queue_cmd(CMD_LBOUND, 8'd0, 32'sd9);        // every entry smaller: the count
        queue_cmd(CMD_SPARE_6, 8'hFF, '1);
        queue_cmd(CMD_SPARE_7, 8'd0, 32'sd0);

        // Random: epochs that steer the table toward a target size with inserts
        // at the sorted slot and deletes, mixed with searches and some noise.
        // Noisy epochs may break the order; empty the table after those.
        first_random = jobs_total;
        ordered      = 1'b1;
        epoch        = 0;
        while (jobs_total - first_random < RAND_ITEMS) begin
            epoch++;
            noisy = ($urandom_range(0, 3) == 0);
            if (epoch == 3) begin
                // One epoch fills the table to the top and pushes against full.
                target = DEPTH;
                n_ops  = 330;
            end else begin
                r      = $urandom_range(0, 99);
                target = (r < 70) ? $urandom_range(0, 24) :
                         (r < 95) ? $urandom_range(25, 100) : $urandom_range(101, 200);
                n_ops  = $urandom_range(25, 70);
            end
            for (k = 0; k < n_ops; k++) begin
                r = $urandom_range(0, 99);
                v = pick_value();
                p = POS_W'($urandom);
                if (r < ((target == DEPTH) ? 95 : 30) && shadow_count != target) begin
                    if (shadow_count < target) begin
                        slot = 0;
                        for (i = 0; i < shadow_count; i++)
                            if (shadow_entry[i] < v)
                                slot++;
                        if (slot == shadow_count && $urandom_range(0, 1) == 1)
                            queue_cmd(CMD_APPEND, p, v);
                        else
                            queue_cmd(CMD_INSERT, POS_W'(slot), v);
                    end else begin
                        queue_cmd(CMD_DELETE, POS_W'($urandom_range(0, shadow_count - 1)), v);
                    end
                end else if (r < 85) begin
                    sel = $urandom_range(0, 2);
                    queue_cmd((sel == 0) ? CMD_LSEARCH : (sel == 1) ? CMD_BEXACT : CMD_LBOUND,
                              p, v);
                end else begin
                    sel = $urandom_range(0, 3);
                    if (shadow_count == DEPTH) begin
                        queue_cmd(sel[0] ? CMD_APPEND : CMD_INSERT, p, v);
                    end else if (sel == 0 && shadow_count < DEPTH - 1) begin
                        queue_cmd(CMD_INSERT,
                                  POS_W'($urandom_range(shadow_count + 1, DEPTH - 1)), v);
                    end else if (sel == 1) begin
                        queue_cmd(CMD_DELETE, POS_W'($urandom_range(shadow_count, DEPTH - 1)), v);
                    end else if (sel == 2 || !noisy) begin
                        queue_cmd(($urandom_range(0, 1) == 1) ? CMD_SPARE_7 : CMD_SPARE_6, p, v);
                    end else begin
                        queue_cmd(CMD_INSERT, POS_W'($urandom_range(0, shadow_count)), v);
                        ordered = 1'b0;
                    end
                end
            end
            // Trim from the tail: cheap, and keeps later shifts short.
            while (shadow_count > 0 && (!ordered || shadow_count > TRIM_LEVEL))
                queue_cmd(CMD_DELETE, POS_W'(shadow_count - 1), pick_value());
            if (shadow_count == 0)
                ordered = 1'b1;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every result, then give a stray one time to show up.
        wait (replies_seen == jobs_total);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (replies_due.size() != 0) begin
            $error("%0d results never arrived", replies_due.size());
            fail_count++;
        end

        $display("%0d items in %0d cycles: append %0d insert %0d delete %0d search %0d no-op %0d",
                 jobs_total, cycle_count, cmd_tally[CMD_APPEND], cmd_tally[CMD_INSERT],
                 cmd_tally[CMD_DELETE],
                 cmd_tally[CMD_LSEARCH] + cmd_tally[CMD_BEXACT] + cmd_tally[CMD_LBOUND],
                 cmd_tally[CMD_SPARE_6] + cmd_tally[CMD_SPARE_7]);
        $display("statuses ok %0d, full %0d, bad %0d, not found %0d; peak fill %0d of %0d",
                 status_tally[STAT_OK], status_tally[STAT_FULL], status_tally[STAT_BAD],
                 status_tally[STAT_MISS], peak_count, DEPTH);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
